// ----- hw/rtl/tad_pkg.sv -----
// ============================================================================
// tad_pkg
// Shared widths, constants and the segment table for the temperature averager.
// ============================================================================
`default_nettype none

package tad_pkg;

    // Sample and value widths
    localparam int RAW_W   = 10;
    localparam int CAL_W   = 13;
    localparam int DIGIT_W = 4;
    localparam int SEG_W   = 8;

    // Ring geometry
    localparam int AVG_DEPTH = 5;
    localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W     = CAL_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);

    // Scale to tenths: sample * 5000 >> 10
    localparam int SCALE_MUL   = 5000;
    localparam int SCALE_MUL_W = 13;
    localparam int SCALE_SHIFT = 10;
    localparam int SCALE_PROD_W = RAW_W + SCALE_MUL_W;

    // Calibration: scaled / 20 = (scaled >> 2) / 5 = ((scaled >> 2) * 3277) >> 14
    localparam int CAL_PRE_SHIFT = 2;
    localparam int CAL_X_W       = CAL_W - CAL_PRE_SHIFT;
    localparam int CAL_RECIP     = 3277;
    localparam int CAL_RECIP_W   = 12;
    localparam int CAL_RSHIFT    = 14;
    localparam int CAL_PROD_W    = CAL_X_W + CAL_RECIP_W;

    // Average: sum / AVG_DEPTH by reciprocal, exact for all sums below 2**SUM_W
    localparam int AVG_SHIFT   = SUM_W + 4;
    localparam int AVG_RECIP   = ((1 << AVG_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int AVG_RECIP_W = AVG_SHIFT + 1;
    localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

    // Decimal split: v / 10 = (v * 13108) >> 17, exact for 13-bit v
    localparam int DIV10_RECIP   = 13108;
    localparam int DIV10_RECIP_W = 14;
    localparam int DIV10_SHIFT   = 17;
    localparam int DIV10_PROD_W  = CAL_W + DIV10_RECIP_W;
    localparam int NUM_DIGITS    = 3;
    localparam int DIG_CNT_W     = 2;

    localparam logic [SEG_W-1:0] DOT_BIT = 8'b00000100;

    // Request from the sequencer to the history ring
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [CAL_W-1:0] wdata;
    } ring_req_t;

    function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pattern;
        case (digit)
            4'd0:    pattern = 8'b11101011;
            4'd1:    pattern = 8'b10001000;
            4'd2:    pattern = 8'b10110011;
            4'd3:    pattern = 8'b10111010;
            4'd4:    pattern = 8'b11011000;
            4'd5:    pattern = 8'b01111010;
            4'd6:    pattern = 8'b01111011;
            4'd7:    pattern = 8'b10101000;
            4'd8:    pattern = 8'b11111011;
            4'd9:    pattern = 8'b11111010;
            default: pattern = '0;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tad_ram.sv -----
// ============================================================================
// tad_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module tad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tad_ring.sv -----
// ============================================================================
// tad_ring
// History ring in RAM with per-entry valid bits, write slot and running sum.
// ============================================================================
`default_nettype none

module tad_ring
    import tad_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ring_req_t        req,
    output logic      [SUM_W-1:0] sum
);

    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [AVG_DEPTH-1:0] valid_reg;
    logic                 old_valid_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic [CAL_W-1:0]     rdata;
    logic [CAL_W-1:0]     old_value;

    tad_ram #(
        .WIDTH (CAL_W),
        .DEPTH (AVG_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (slot_reg),
        .wdata (req.wdata),
        .re    (req.rd_en),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    // An entry never written since reset reads as zero
    assign old_value = old_valid_reg ? rdata : '0;

    always_comb
    begin
        if (slot_reg == SLOT_W'(AVG_DEPTH - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
        sum_next = sum_reg - SUM_W'(old_value) + SUM_W'(req.wdata);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            if (req.rd_en)
            begin
                old_valid_reg <= valid_reg[slot_reg];
            end
            if (req.wr_en)
            begin
                valid_reg[slot_reg] <= 1'b1;
                sum_reg             <= sum_next;
                slot_reg            <= slot_next;
            end
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/temperature_average_display.sv -----
// ============================================================================
// temperature_average_display
// Scales and calibrates a converter sample, keeps a five-deep moving average
// in RAM and decodes the average into seven-segment digit patterns.
// ============================================================================
// Sequence: a sample word passes the scale, calibrate, ring-write and average
//   states and the three-step decimal split, then loads the output register;
//   the sequencer handles one word at a time and takes a new one only when idle.
// Reset: rst_n clears the sequencer, the output valid, the write slot, the
//   running sum and the ring valid bits; the ring RAM itself is not cleared,
//   unwritten entries read as zero through their valid bits.
`default_nettype none

module temperature_average_display
    import tad_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [RAW_W-1:0] sample,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [CAL_W-1:0] average_tenths,
    output logic      [SEG_W-1:0] seg_tenths,
    output logic      [SEG_W-1:0] seg_units,
    output logic      [SEG_W-1:0] seg_tens,
    output logic                  tens_lit
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_CAL   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_AVG   = 3'd4;
    localparam logic [2:0] ST_DIG   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg;
    logic                   out_valid_reg;

    logic [RAW_W-1:0]       raw_reg;
    logic [CAL_W-1:0]       scaled_reg;
    logic [CAL_W-1:0]       cal_reg;
    logic [CAL_W-1:0]       avg_reg;
    logic [CAL_W-1:0]       rem_reg;
    logic [DIGIT_W-1:0]     dig_reg [NUM_DIGITS];

    logic [CAL_W-1:0]       average_tenths_reg;
    logic [SEG_W-1:0]       seg_tenths_reg;
    logic [SEG_W-1:0]       seg_units_reg;
    logic [SEG_W-1:0]       seg_tens_reg;
    logic                   tens_lit_reg;

    logic                   in_accept;
    logic                   out_load;
    logic                   out_free;
    ring_req_t              ring_req;
    logic [SUM_W-1:0]       ring_sum;

    logic [SCALE_PROD_W-1:0] scale_prod;
    logic [CAL_PROD_W-1:0]   cal_prod;
    logic [CAL_W-1:0]        cal_value;
    logic [AVG_PROD_W-1:0]   avg_prod;
    logic [DIV10_PROD_W-1:0] div10_prod;
    logic [CAL_W-1:0]        quot10;
    logic [CAL_W-1:0]        times10;
    logic [DIGIT_W-1:0]      digit;
    logic                    tens_nz;

    // ------------------------------------------------------------------------
    // Handshake: take a word only when the sequencer is idle. The output
    // register frees on the same edge it is drained.
    // ------------------------------------------------------------------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_OUT) && out_free;

    // ------------------------------------------------------------------------
    // Ring access: read the slot being replaced on accept, write the new
    // calibrated value back in ST_SUM. Only one word is in flight, so the
    // read and the write of a slot never overlap with another word.
    // ------------------------------------------------------------------------
    always_comb
    begin
        ring_req.rd_en = in_accept;
        ring_req.wr_en = (state_reg == ST_SUM);
        ring_req.wdata = cal_reg;
    end

    tad_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .sum   (ring_sum)
    );

    // ------------------------------------------------------------------------
    // Arithmetic, one multiplier per state
    // ------------------------------------------------------------------------
    always_comb
    begin
        // Scale to tenths of a degree
        scale_prod = SCALE_PROD_W'(raw_reg) * SCALE_PROD_W'(SCALE_MUL);

        // Subtract a twentieth as calibration
        cal_prod  = CAL_PROD_W'(scaled_reg[CAL_W-1:CAL_PRE_SHIFT]) * CAL_PROD_W'(CAL_RECIP);
        cal_value = scaled_reg - CAL_W'(cal_prod >> CAL_RSHIFT);

        // Ring sum over depth by reciprocal
        avg_prod = AVG_PROD_W'(ring_sum) * AVG_PROD_W'(AVG_RECIP);

        // One decimal digit per step
        div10_prod = DIV10_PROD_W'(rem_reg) * DIV10_PROD_W'(DIV10_RECIP);
        quot10     = CAL_W'(div10_prod >> DIV10_SHIFT);
        times10    = (quot10 << 3) + (quot10 << 1);
        digit      = DIGIT_W'(rem_reg - times10);

        tens_nz = (dig_reg[2] != '0);
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_CAL;
            ST_CAL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_AVG;
            ST_AVG:   state_next = ST_DIG;
            ST_DIG:
            begin
                if (dig_cnt_reg == DIG_CNT_W'(NUM_DIGITS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIG)
            begin
                dig_cnt_reg <= dig_cnt_reg + DIG_CNT_W'(1);
            end
            else
            begin
                dig_cnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            raw_reg <= sample;
        end
        if (state_reg == ST_SCALE)
        begin
            scaled_reg <= CAL_W'(scale_prod >> SCALE_SHIFT);
        end
        if (state_reg == ST_CAL)
        begin
            cal_reg <= cal_value;
        end
        if (state_reg == ST_AVG)
        begin
            avg_reg <= CAL_W'(avg_prod >> AVG_SHIFT);
            rem_reg <= CAL_W'(avg_prod >> AVG_SHIFT);
        end
        if (state_reg == ST_DIG)
        begin
            // Peel off tenths, then units, then tens
            dig_reg[dig_cnt_reg] <= digit;
            rem_reg              <= quot10;
        end
        if (out_load)
        begin
            average_tenths_reg <= avg_reg;
            seg_tenths_reg     <= seg_encode(dig_reg[0]);
            seg_units_reg      <= seg_encode(dig_reg[1]) | DOT_BIT;
            seg_tens_reg       <= tens_nz ? seg_encode(dig_reg[2]) : '0;
            tens_lit_reg       <= tens_nz;
        end
    end

    assign out_valid      = out_valid_reg;
    assign average_tenths = average_tenths_reg;
    assign seg_tenths     = seg_tenths_reg;
    assign seg_units      = seg_units_reg;
    assign seg_tens       = seg_tens_reg;
    assign tens_lit       = tens_lit_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_write_follows_read: assert property (
        @(posedge clk) disable iff (!rst_n)
        ring_req.wr_en |-> $past(ring_req.rd_en, 3)
    ) else $error("ring write without matching read of its slot");

    a_hold_until_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && out_valid_reg && out_stall |=> (state_reg == ST_OUT)
    ) else $error("result dropped over a stalled output word");

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall && (state_reg == ST_SCALE)
    ) else $error("second word taken while one is in flight");

endmodule

`default_nettype wire
